// ===== design/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg: shared types for the page bitmap allocator
// Command format passed from the front end to the back end, status codes
// and back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package pba_pkg;

    // page numbers: a 32-bit address over a page of at least 256 bytes,
    // plus room for the page count of the largest bitmap
    localparam int PAGE_W = 25;

    typedef enum logic [1:0] {
        KIND_ALLOC      = 2'd0,
        KIND_FREE       = 2'd1,
        KIND_MARK_USED  = 2'd2,
        KIND_MARK_FREE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_PAGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_INVALID = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic                mark_set;   // 1: pages become available
        logic                clear_exh;  // single-page free clears exhausted
        logic [PAGE_W-1:0]   first;      // first page to mark
        logic [PAGE_W-1:0]   last;       // exclusive end page, capped
    } cmd_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN_RD,
        BK_SCAN_CHK,
        BK_MARK_RD,
        BK_MARK_WR,
        BK_RESP
    } bk_state_t;

endpackage
`default_nettype wire

// ===== design/pba_front.sv =====
// ----------------------------------------------------------------------------
// pba_front: request classifier
// Checks alignment and ordering of the addresses and turns each request
// into a command with page bounds clipped to the bitmap.
// ----------------------------------------------------------------------------
`default_nettype none
module pba_front #(
    parameter int PAGE_BYTES   = 4096,
    parameter int BITMAP_BYTES = 131072
) (
    input  wire logic [1:0]     kind,
    input  wire logic [31:0]    req_base,
    input  wire logic [31:0]    req_limit,
    output pba_pkg::cmd_t       cmd
);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [pba_pkg::PAGE_W-1:0] CAP =
        pba_pkg::PAGE_W'(BITMAP_BYTES * 8);

    logic                        start_mis;
    logic                        end_mis;
    logic [pba_pkg::PAGE_W-1:0]  ps;
    logic [pba_pkg::PAGE_W-1:0]  pe;
    logic [pba_pkg::PAGE_W-1:0]  ps_inc;

    assign start_mis = req_base[PAGE_SHIFT-1:0] != '0;
    assign end_mis   = req_limit[PAGE_SHIFT-1:0] != '0;
    assign ps        = pba_pkg::PAGE_W'(req_base >> PAGE_SHIFT);
    assign pe        = pba_pkg::PAGE_W'(req_limit >> PAGE_SHIFT);
    assign ps_inc    = ps + pba_pkg::PAGE_W'(1);

    // classify the request
    always_comb begin
        cmd.op        = pba_pkg::CMD_ALLOC;
        cmd.mark_set  = 1'b0;
        cmd.clear_exh = 1'b0;
        cmd.first     = ps;
        cmd.last      = ps;
        unique case (pba_pkg::kind_t'(kind))
            pba_pkg::KIND_ALLOC: begin
                cmd.op = pba_pkg::CMD_ALLOC;
            end
            pba_pkg::KIND_FREE: begin
                if (start_mis) begin
                    cmd.op = pba_pkg::CMD_INVALID;
                end else begin
                    cmd.op        = pba_pkg::CMD_MARK;
                    cmd.mark_set  = 1'b1;
                    cmd.clear_exh = 1'b1;
                    cmd.last      = (ps_inc > CAP) ? CAP : ps_inc;
                end
            end
            default: begin
                if (start_mis || end_mis || req_limit < req_base) begin
                    cmd.op = pba_pkg::CMD_INVALID;
                end else begin
                    cmd.op       = pba_pkg::CMD_MARK;
                    cmd.mark_set = kind == pba_pkg::KIND_MARK_FREE;
                    cmd.last     = (pe > CAP) ? CAP : pe;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/pba_queue.sv =====
// ----------------------------------------------------------------------------
// pba_queue: two-entry command queue
// Decouples request acceptance from bitmap work.
// ----------------------------------------------------------------------------
`default_nettype none
module pba_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire pba_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output pba_pkg::cmd_t       head
);
    pba_pkg::cmd_t  slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rd_ptr_reg];

    // store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/pba_back.sv =====
// ----------------------------------------------------------------------------
// pba_back: bitmap engine
// Holds the availability bitmap, clears it after reset, scans it for
// allocation, walks byte masks for range marking and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none
module pba_back #(
    parameter int PAGE_BYTES   = 4096,
    parameter int BITMAP_BYTES = 131072
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [16:0]    search_start_byte,
    input  wire logic           cmd_valid,
    input  wire pba_pkg::cmd_t  cmd,
    output logic                cmd_pop,
    output logic                clear_busy,
    output logic                res_valid,
    input  wire logic           res_ready,
    output logic [1:0]          res_status,
    output logic [31:0]         res_address
);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int IW = 18;
    localparam int PW = pba_pkg::PAGE_W;
    localparam logic [IW-1:0] NBYTES = IW'(BITMAP_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_BYTES - 1);

    logic [7:0]             mem [BITMAP_BYTES];
    logic [7:0]             rd_data;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [7:0]             wr_data;

    pba_pkg::bk_state_t     state_reg, state_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   exh_reg, exh_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [PW-1:0]          p_reg, p_next;
    logic [PW-1:0]          last_reg, last_next;
    logic                   set_reg, set_next;
    logic [1:0]             st_reg, st_next;
    logic [31:0]            addr_reg, addr_next;
    logic                   ov_reg, ov_next;
    logic [1:0]             ost_reg, ost_next;
    logic [31:0]            oaddr_reg, oaddr_next;

    logic [2:0]             top;
    logic [IW-1:0]          idx_inc;
    logic [PW-1:0]          byte_base;
    logic [PW-1:0]          p_adv;
    logic [PW-1:0]          rem;
    logic [2:0]             hi;
    logic [7:0]             mask;
    logic [IW+2:0]          page_found;

    // bitmap memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // highest set bit of the byte read
    always_comb begin
        top = 3'd0;
        for (int b = 1; b < 8; b++) begin
            if (rd_data[b]) top = 3'(b);
        end
    end

    assign idx_inc    = idx_reg + IW'(1);
    assign byte_base  = {p_reg[PW-1:3], 3'b000};
    assign p_adv      = {p_reg[PW-1:3] + (PW-3)'(1), 3'b000};
    assign rem        = last_reg - byte_base;
    assign hi         = (rem >= PW'(8)) ? 3'd7 : (rem[2:0] - 3'd1);
    assign mask       = (8'hFF << p_reg[2:0]) & (8'hFF >> (3'd7 - hi));
    assign page_found = {idx_reg, top};

    assign clear_busy  = state_reg == pba_pkg::BK_CLEAR;
    assign res_valid   = ov_reg;
    assign res_status  = ost_reg;
    assign res_address = oaddr_reg;

    // next state and memory control
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        exh_next   = exh_reg;
        idx_next   = idx_reg;
        p_next     = p_reg;
        last_next  = last_reg;
        set_next   = set_reg;
        st_next    = st_reg;
        addr_next  = addr_reg;
        ov_next    = ov_reg && !res_ready;
        ost_next   = ost_reg;
        oaddr_next = oaddr_reg;
        cmd_pop    = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = clr_reg;
        wr_data    = 8'h00;
        unique case (state_reg)
            pba_pkg::BK_CLEAR: begin
                wr_en = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR) state_next = pba_pkg::BK_IDLE;
            end
            pba_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop   = 1'b1;
                    st_next   = pba_pkg::ST_OK;
                    addr_next = 32'd0;
                    p_next    = cmd.first;
                    last_next = cmd.last;
                    set_next  = cmd.mark_set;
                    unique case (cmd.op)
                        pba_pkg::CMD_ALLOC: begin
                            idx_next = IW'(search_start_byte);
                            if (exh_reg) begin
                                st_next    = pba_pkg::ST_NO_PAGE;
                                state_next = pba_pkg::BK_RESP;
                            end else if (IW'(search_start_byte) >= NBYTES) begin
                                exh_next   = 1'b1;
                                st_next    = pba_pkg::ST_NO_PAGE;
                                state_next = pba_pkg::BK_RESP;
                            end else begin
                                state_next = pba_pkg::BK_SCAN_RD;
                            end
                        end
                        pba_pkg::CMD_MARK: begin
                            if (cmd.clear_exh) exh_next = 1'b0;
                            state_next = (cmd.first < cmd.last) ?
                                pba_pkg::BK_MARK_RD : pba_pkg::BK_RESP;
                        end
                        default: begin
                            st_next    = pba_pkg::ST_INVALID;
                            state_next = pba_pkg::BK_RESP;
                        end
                    endcase
                end
            end
            pba_pkg::BK_SCAN_RD: begin
                rd_addr    = idx_reg[AW-1:0];
                state_next = pba_pkg::BK_SCAN_CHK;
            end
            pba_pkg::BK_SCAN_CHK: begin
                if (rd_data != 8'h00) begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg[AW-1:0];
                    wr_data    = rd_data & ~(8'h01 << top);
                    addr_next  = 32'(34'(page_found) << PAGE_SHIFT);
                    state_next = pba_pkg::BK_RESP;
                end else if (idx_inc >= NBYTES) begin
                    exh_next   = 1'b1;
                    st_next    = pba_pkg::ST_NO_PAGE;
                    state_next = pba_pkg::BK_RESP;
                end else begin
                    idx_next   = idx_inc;
                    state_next = pba_pkg::BK_SCAN_RD;
                end
            end
            pba_pkg::BK_MARK_RD: begin
                rd_addr    = p_reg[3 +: AW];
                state_next = pba_pkg::BK_MARK_WR;
            end
            pba_pkg::BK_MARK_WR: begin
                wr_en   = 1'b1;
                wr_addr = p_reg[3 +: AW];
                wr_data = set_reg ? (rd_data | mask) : (rd_data & ~mask);
                p_next  = p_adv;
                state_next = (p_adv < last_reg) ?
                    pba_pkg::BK_MARK_RD : pba_pkg::BK_RESP;
            end
            pba_pkg::BK_RESP: begin
                if (!ov_reg || res_ready) begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    oaddr_next = addr_reg;
                    state_next = pba_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = pba_pkg::BK_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pba_pkg::BK_CLEAR;
            clr_reg   <= '0;
            exh_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            exh_reg   <= exh_next;
            ov_reg    <= ov_next;
        end
    end

    // hold working values
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        p_reg     <= p_next;
        last_reg  <= last_next;
        set_reg   <= set_next;
        st_reg    <= st_next;
        addr_reg  <= addr_next;
        ost_reg   <= ost_next;
        oaddr_reg <= oaddr_next;
    end

endmodule
`default_nettype wire

// ===== design/page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_allocator: bitmap physical page allocator
// One availability bit per page; allocate, free and range marking requests.
// ----------------------------------------------------------------------------
// After reset the block clears the bitmap byte by byte and accepts no
// request until then. Each request then does its bitmap work: an allocate
// reads bitmap bytes one at a time from search_start_byte until it hits a
// nonzero byte or the end of the bitmap, a range marking reads and rewrites
// each byte the range touches, and rejected requests or allocate while
// exhausted go straight to the response. Up to two requests queue while
// the engine is busy.
`default_nettype none
module page_bitmap_allocator #(
    parameter int PAGE_BYTES   = 4096,
    parameter int BITMAP_BYTES = 131072
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic [16:0]    cfg_wdata,     // search_start_byte
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [63:0]    s_tdata,       // req_base, req_limit
    input  wire logic [1:0]     s_tuser,       // kind
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata,       // alloc_addr
    output logic [1:0]          m_tuser        // status
);
    logic [16:0]        start_byte_reg;
    pba_pkg::cmd_t      front_cmd;
    pba_pkg::cmd_t      head_cmd;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               clear_busy;
    logic               s_xfer;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= 17'd32;
        end else if (cfg_we) begin
            start_byte_reg <= cfg_wdata;
        end
    end

    assign s_tready = !q_full && !clear_busy;
    assign s_xfer   = s_tvalid && s_tready;

    pba_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_front (
        .kind      (s_tuser),
        .req_base  (s_tdata[31:0]),
        .req_limit (s_tdata[63:32]),
        .cmd       (front_cmd)
    );

    pba_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_xfer),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head_cmd)
    );

    pba_back #(
        .PAGE_BYTES   (PAGE_BYTES),
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .search_start_byte (start_byte_reg),
        .cmd_valid         (q_valid),
        .cmd               (head_cmd),
        .cmd_pop           (q_pop),
        .clear_busy        (clear_busy),
        .res_valid         (m_tvalid),
        .res_ready         (m_tready),
        .res_status        (m_tuser),
        .res_address       (m_tdata)
    );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the page bitmap allocator
// Drives allocate, free and range requests over the input stream, tracks the
// page bitmap and exhausted flag in a scoreboard and checks each response in
// order. The search start register is changed between traffic phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int PG_BYTES   = 4096;
    localparam int MAP_BYTES  = 131072;
    localparam int MAP_PAGES  = MAP_BYTES * 8;
    localparam int WIN_PAGES  = 256;
    localparam int IDLE_LIMIT = 1500000;
    localparam int PHASE_ITEMS = 420;

    // ------------------------------------------------------------------------
    // Scoreboard: page bitmap tracker with in-order response check
    // ------------------------------------------------------------------------
    class alloc_tracker;
        bit [7:0]          avail_map [MAP_BYTES];
        bit                exhausted;
        bit [16:0]         start_byte;
        pba_pkg::status_t  exp_status [$];
        bit [31:0]         exp_addr [$];
        int                errors;

        function new();
            exhausted  = 0;
            start_byte = 17'd32;
            errors     = 0;
        endfunction

        function void set_start(bit [16:0] v);
            start_byte = v;
        endfunction

        function int pending();
            return exp_status.size();
        endfunction

        // allocate stays short when exhausted or a page lies near the start byte
        function bit alloc_is_short();
            int hi;
            if (exhausted || start_byte >= 17'd131000)
                return 1;
            hi = start_byte + 40;
            for (int i = start_byte; i <= hi; i++)
                if (avail_map[i] != 0)
                    return 1;
            return 0;
        endfunction

        function void mark_page(longint unsigned pg, bit val);
            if (pg < MAP_PAGES)
                avail_map[pg / 8][pg % 8] = val;
        endfunction

        // compute the response for one accepted request
        function void note_request(pba_pkg::kind_t kind, bit [31:0] saddr,
                                   bit [31:0] eaddr);
            pba_pkg::status_t st;
            bit [31:0] pa;
            longint unsigned pg, last;
            bit found;
            st = pba_pkg::ST_OK;
            pa = '0;
            found = 0;
            case (kind)
                pba_pkg::KIND_ALLOC: begin
                    if (exhausted) begin
                        st = pba_pkg::ST_NO_PAGE;
                    end else begin
                        for (int i = start_byte; i < MAP_BYTES && !found; i++) begin
                            if (avail_map[i] != 0) begin
                                for (int b = 7; b >= 0 && !found; b--) begin
                                    if (avail_map[i][b]) begin
                                        avail_map[i][b] = 0;
                                        pg = i * 8 + b;
                                        pa = 32'(pg * PG_BYTES);
                                        found = 1;
                                    end
                                end
                            end
                        end
                        if (!found) begin
                            exhausted = 1;
                            st = pba_pkg::ST_NO_PAGE;
                        end
                    end
                end
                pba_pkg::KIND_FREE: begin
                    if (saddr[11:0] != 0) begin
                        st = pba_pkg::ST_INVALID;
                    end else begin
                        mark_page(saddr >> 12, 1);
                        exhausted = 0;
                    end
                end
                default: begin
                    if (saddr[11:0] != 0 || eaddr[11:0] != 0 || eaddr < saddr) begin
                        st = pba_pkg::ST_INVALID;
                    end else begin
                        last = eaddr >> 12;
                        if (last > MAP_PAGES)
                            last = MAP_PAGES;
                        for (pg = saddr >> 12; pg < last; pg++)
                            mark_page(pg, kind == pba_pkg::KIND_MARK_FREE);
                    end
                end
            endcase
            exp_status.push_back(st);
            exp_addr.push_back(pa);
        endfunction

        function void report(string what, longint unsigned exp_v, longint unsigned act_v);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
        endfunction

        function void check_response(pba_pkg::status_t st, bit [31:0] pa);
            pba_pkg::status_t es;
            bit [31:0] ea;
            if (exp_status.size() == 0) begin
                report("unexpected response status", 0, st);
                return;
            end
            es = exp_status.pop_front();
            ea = exp_addr.pop_front();
            if (st !== es)
                report("status", es, st);
            if (pa !== ea)
                report("alloc_addr", ea, pa);
        endfunction
    endclass

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          cfg_we = 0;
    logic [16:0]   cfg_wdata = '0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [63:0]   s_tdata = '0;   // req_base, req_limit
    logic [1:0]    s_tuser = '0;   // kind
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [31:0]   m_tdata;        // alloc_addr
    logic [1:0]    m_tuser;        // status

    alloc_tracker tracker = new();
    int  sent_cnt = 0;
    int  hold_cnt = 0;
    bit  hold_done = 0;
    int  idle_cycles = 0;

    page_bitmap_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // check every response transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_response(pba_pkg::status_t'(m_tuser), m_tdata);
    end

    // receiver: random stalls, one long hold-off, one quiet stretch
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (sent_cnt == 300 && !hold_done) begin
            m_tready  <= 1'b0;
            hold_cnt  <= 400;
            hold_done <= 1'b1;
        end else begin
            m_tready <= (sent_cnt >= 600 && sent_cnt < 900) || ($urandom_range(0, 99) >= 10);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[page_bitmap_allocator] ERROR");
            $finish;
        end
    end

    // offer one request and hold it until the transfer; called at a falling edge
    task automatic send_req(pba_pkg::kind_t kind, bit [31:0] saddr, bit [31:0] eaddr);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {eaddr, saddr};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.note_request(kind, saddr, eaddr);
        sent_cnt++;
        @(negedge aclk);
    endtask

    // random sender gap, none in the quiet stretch
    task automatic sender_gap();
        if (!(sent_cnt >= 600 && sent_cnt < 900) && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    task automatic drain_and_config(bit [16:0] v);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        tracker.set_start(v);
        @(negedge aclk);
    endtask

    function automatic bit [31:0] window_addr();
        longint unsigned base;
        base = longint'(tracker.start_byte) * 8;
        if (base > MAP_PAGES - WIN_PAGES)
            base = MAP_PAGES - WIN_PAGES;
        return 32'((base + $urandom_range(0, WIN_PAGES - 1)) << 12);
    endfunction

    // one random request, weighted toward well-formed traffic near the start byte
    task automatic random_req();
        int r;
        pba_pkg::kind_t k;
        bit [31:0] sa, ea;
        r  = $urandom_range(0, 99);
        sa = window_addr();
        ea = sa + ($urandom_range(0, 24) << 12);
        if (r < 30) begin
            k = pba_pkg::KIND_ALLOC;
            sa = $urandom();
            ea = $urandom();
            if (!tracker.alloc_is_short()) begin
                k = pba_pkg::KIND_FREE;
                sa = window_addr();
            end
        end else if (r < 55) begin
            k = pba_pkg::KIND_FREE;
            ea = $urandom();
            if ($urandom_range(0, 19) == 0)
                sa = {20'($urandom_range(0, 32'hFFFFF)), 12'h000};
            else if ($urandom_range(0, 29) == 0)
                sa[11:0] = 12'($urandom_range(1, 4095));
        end else if (r < 70) begin
            k = pba_pkg::KIND_MARK_FREE;
        end else if (r < 82) begin
            k = pba_pkg::KIND_MARK_USED;
        end else if (r < 92) begin
            // malformed range: misaligned or reversed
            k = $urandom_range(0, 1) ? pba_pkg::KIND_MARK_USED : pba_pkg::KIND_MARK_FREE;
            case ($urandom_range(0, 2))
                0: sa[11:0] = 12'($urandom_range(1, 4095));
                1: ea[11:0] = 12'($urandom_range(1, 4095));
                default: begin
                    ea = sa;
                    sa = ea + ($urandom_range(1, 8) << 12);
                end
            endcase
        end else begin
            // noise with full-width fields
            k  = pba_pkg::kind_t'(2'($urandom_range(1, 3)));
            sa = $urandom();
            ea = $urandom();
            if (k != pba_pkg::KIND_FREE && sa[11:0] == 0)
                sa[0] = 1'b1;
        end
        send_req(k, sa, ea);
    endtask

    initial begin
        bit [16:0] starts [4];
        starts = '{17'd0, 17'd131071, 17'd0, 17'd32};
        starts[2] = 17'($urandom_range(1, 130000));
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty bitmap, exhaustion, recovery, argument checks
        send_req(pba_pkg::KIND_ALLOC, 32'h0, 32'h0);
        send_req(pba_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(pba_pkg::KIND_MARK_FREE, 32'h0010_0000, 32'h0010_8000);
        send_req(pba_pkg::KIND_ALLOC, 32'h0, 32'h0);
        send_req(pba_pkg::KIND_FREE, 32'h0011_0000, 32'hFFFF_FFFF);
        send_req(pba_pkg::KIND_ALLOC, 32'h0, 32'h0);
        send_req(pba_pkg::KIND_ALLOC, 32'h0, 32'h0);
        send_req(pba_pkg::KIND_FREE, 32'h0010_0001, 32'h0);
        send_req(pba_pkg::KIND_FREE, 32'hFFFF_FFFF, 32'h0);
        send_req(pba_pkg::KIND_MARK_USED, 32'h0010_0800, 32'h0010_4000);
        send_req(pba_pkg::KIND_MARK_FREE, 32'h0010_0000, 32'hFFFF_FFFF);
        send_req(pba_pkg::KIND_MARK_USED, 32'h0010_4000, 32'h0010_0000);
        send_req(pba_pkg::KIND_MARK_FREE, 32'hFFFF_F000, 32'hFFFF_F000);
        send_req(pba_pkg::KIND_MARK_USED, 32'h0, 32'h0);
        send_req(pba_pkg::KIND_FREE, 32'hFFFF_F000, 32'h0);
        send_req(pba_pkg::KIND_FREE, 32'h0000_0000, 32'h0);
        send_req(pba_pkg::KIND_MARK_FREE, 32'hFFFF_8000, 32'hFFFF_F000);
        send_req(pba_pkg::KIND_MARK_USED, 32'h0010_0000, 32'h0010_4000);
        send_req(pba_pkg::KIND_ALLOC, 32'h0, 32'h0);
        send_req(pba_pkg::KIND_ALLOC, 32'h0, 32'h0);

        // random phases over several search start settings
        foreach (starts[p]) begin
            drain_and_config(starts[p]);
            repeat (PHASE_ITEMS) begin
                sender_gap();
                random_req();
            end
        end

        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.errors == 0)
            $display("[page_bitmap_allocator] OK");
        else
            $display("[page_bitmap_allocator] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
